// ----- rtl/npd_pkg.sv -----
// ----------------------------------------------------------------------------
// npd_pkg: shared types and constants of the navigation PGN decoder
// Result kind codes, handled PGN numbers, not-available markers and the
// fixed-point constants of the angle and speed conversions.
// ----------------------------------------------------------------------------
package npd_pkg;

  typedef enum logic [3:0] {
    KIND_NONE            = 4'd0,
    KIND_POSITION        = 4'd1,
    KIND_COG_SOG         = 4'd2,
    KIND_HDG_TRUE        = 4'd3,
    KIND_HDG_MAG         = 4'd4,
    KIND_VAR_ONLY        = 4'd5,
    KIND_DEPTH           = 4'd6,
    KIND_WATER_SPEED     = 4'd7,
    KIND_APPARENT_WIND   = 4'd8,
    KIND_TRUE_WIND_BOAT  = 4'd9,
    KIND_TRUE_WIND_NORTH = 4'd10
  } kind_t;

  localparam logic [17:0] PGN_POSITION    = 18'd129025;
  localparam logic [17:0] PGN_COG_SOG     = 18'd129026;
  localparam logic [17:0] PGN_HEADING     = 18'd127250;
  localparam logic [17:0] PGN_DEPTH       = 18'd128267;
  localparam logic [17:0] PGN_WATER_SPEED = 18'd128259;
  localparam logic [17:0] PGN_WIND        = 18'd130306;

  localparam logic [15:0] NA16  = 16'hFFFF;
  localparam logic [31:0] NA32  = 32'hFFFF_FFFF;
  localparam logic [15:0] NAI16 = 16'h7FFF;
  localparam logic [31:0] NAI32 = 32'h7FFF_FFFF;

  // Course over ground reference
  localparam logic [1:0] CREF_TRUE = 2'd0;

  // Wind angle references
  localparam logic [2:0] WREF_TRUE_NORTH = 3'd0;
  localparam logic [2:0] WREF_APPARENT   = 3'd2;
  localparam logic [2:0] WREF_BOAT_A     = 3'd3;
  localparam logic [2:0] WREF_BOAT_B     = 3'd4;

  // Heading references
  localparam logic [1:0] HREF_TRUE = 2'd0;
  localparam logic [1:0] HREF_MAG  = 2'd1;

  localparam logic [18:0] FULL_TURN = 19'd360000;

  // 18/pi in Q32, split as K_HI * 2^17 + K_LO
  localparam logic [17:0] ANG_K_HI  = 18'd187746;
  localparam logic [16:0] ANG_K_LO  = 17'd106209;
  localparam logic [31:0] ANG_ROUND = 32'h8000_0000;

  // mknots = (raw * 18000 + 463) / 926, quotient via floor(2^32 / 926)
  localparam logic [14:0] SPD_MUL   = 15'd18000;
  localparam logic [8:0]  SPD_BIAS  = 9'd463;
  localparam logic [9:0]  SPD_DIV   = 10'd926;
  localparam logic [22:0] SPD_RECIP = 23'd4638193;

  typedef struct packed {
    logic [20:0] q_est;
    logic [10:0] rem;
  } spd_part_t;

endpackage

// ----- rtl/npd_ang_conv.sv -----
// ----------------------------------------------------------------------------
// npd_ang_conv: raw angle magnitude to rounded millidegrees
// Two register stages: Q32 partial products, then sum, round and shift.
// ----------------------------------------------------------------------------
module npd_ang_conv (
  input  logic        clk,
  input  logic [16:0] mag,
  output logic [18:0] mdeg
);

  logic [33:0] pp_hi;
  logic [32:0] pp_lo;
  logic [50:0] sum;

  always_ff @(posedge clk) begin
    pp_hi <= 34'(mag) * 34'(npd_pkg::ANG_K_HI);
    pp_lo <= 33'(mag) * 33'(npd_pkg::ANG_K_LO);
  end

  assign sum = {pp_hi, 17'd0} + 51'(pp_lo) + 51'(npd_pkg::ANG_ROUND);

  always_ff @(posedge clk) begin
    mdeg <= sum[50:32];
  end

endmodule

// ----- rtl/npd_spd_conv.sv -----
// ----------------------------------------------------------------------------
// npd_spd_conv: raw speed (0.01 m/s) to milliknots, first three stages
// Scales and biases, estimates the quotient by 926 with a reciprocal and
// forms the remainder; the caller adds one when the remainder reaches 926.
// ----------------------------------------------------------------------------
module npd_spd_conv (
  input  logic               clk,
  input  logic [15:0]        raw,
  output npd_pkg::spd_part_t part
);

  logic [30:0] num1;
  logic [30:0] num2;
  logic [20:0] q_est2;
  logic [53:0] recip_prod;
  logic [30:0] rem_full;

  always_ff @(posedge clk) begin
    num1 <= 31'(raw) * 31'(npd_pkg::SPD_MUL) + 31'(npd_pkg::SPD_BIAS);
  end

  // estimate is the true quotient or one below it
  assign recip_prod = 54'(num1) * 54'(npd_pkg::SPD_RECIP);

  always_ff @(posedge clk) begin
    num2   <= num1;
    q_est2 <= recip_prod[52:32];
  end

  assign rem_full = num2 - 31'(q_est2) * 31'(npd_pkg::SPD_DIV);

  always_ff @(posedge clk) begin
    part.q_est <= q_est2;
    part.rem   <= rem_full[10:0];
  end

endmodule

// ----- rtl/nav_pgn_decoder_core.sv -----
// ----------------------------------------------------------------------------
// nav_pgn_decoder_core: navigation PGN decoder
// Decodes single-frame position, COG/SOG, heading, depth, water speed and
// wind messages into fixed-point values with one result per request.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises.
// Each request gives one result, marked by done for one cycle, in request
// order. A request passes five register stages: decode, multiplier partial
// products, rounding and reciprocal quotient, angle wrap and remainder, and
// the output register. The receiver cannot stall, and none is needed since a
// result is produced every cycle at most.
module nav_pgn_decoder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [17:0]        pgn,
  input  logic [63:0]        payload,
  input  logic [7:0]         payload_len,
  output logic               done,
  output logic               recognized,
  output logic [3:0]         kind,
  output logic signed [36:0] value_a,
  output logic signed [31:0] value_b,
  output logic signed [18:0] variation_mdeg,
  output logic               variation_valid,
  output logic               true_heading_valid
);

  // ---------------- stage 1: decode ----------------
  logic                 dec_rec;
  npd_pkg::kind_t       dec_kind;
  logic                 dec_vv;
  logic [15:0]          dec_ang_raw;
  logic [15:0]          dec_spd_raw;
  logic signed [36:0]   dec_dir_a;
  logic signed [31:0]   dec_dir_b;
  logic                 dec_off_ok;
  logic                 len8;
  logic                 len6;

  logic                 s1_valid;
  logic                 s1_rec;
  npd_pkg::kind_t       s1_kind;
  logic                 s1_vv;
  logic                 s1_vsign;
  logic [15:0]          s1_ang_raw;
  logic [16:0]          s1_var_mag;
  logic [15:0]          s1_spd_raw;
  logic signed [36:0]   s1_dir_a;
  logic signed [31:0]   s1_dir_b;
  logic [15:0]          s1_off;
  logic                 s1_off_ok;

  assign len8 = payload_len >= 8'd8;
  assign len6 = payload_len >= 8'd6;

  always_comb begin
    dec_rec     = 1'b1;
    dec_kind    = npd_pkg::KIND_NONE;
    dec_vv      = 1'b0;
    dec_ang_raw = payload[23:8];
    dec_spd_raw = payload[23:8];
    dec_dir_a   = 37'(signed'(payload[31:0]));
    dec_dir_b   = payload[63:32];
    dec_off_ok  = payload[55:40] != npd_pkg::NAI16;
    case (pgn)
      npd_pkg::PGN_POSITION: begin
        if (len8 && payload[31:0] != npd_pkg::NAI32 && payload[63:32] != npd_pkg::NAI32)
          dec_kind = npd_pkg::KIND_POSITION;
      end
      npd_pkg::PGN_COG_SOG: begin
        dec_ang_raw = payload[31:16];
        dec_spd_raw = payload[47:32];
        if (len8 && payload[31:16] != npd_pkg::NA16 && payload[47:32] != npd_pkg::NA16
            && payload[9:8] == npd_pkg::CREF_TRUE)
          dec_kind = npd_pkg::KIND_COG_SOG;
      end
      npd_pkg::PGN_HEADING: begin
        if (len8 && payload[23:8] != npd_pkg::NA16) begin
          dec_vv = payload[55:40] != npd_pkg::NAI16;
          case (payload[57:56])
            npd_pkg::HREF_TRUE: dec_kind = npd_pkg::KIND_HDG_TRUE;
            npd_pkg::HREF_MAG:  dec_kind = npd_pkg::KIND_HDG_MAG;
            default: begin
              if (dec_vv) dec_kind = npd_pkg::KIND_VAR_ONLY;
            end
          endcase
        end
      end
      npd_pkg::PGN_DEPTH: begin
        dec_dir_a = {5'd0, payload[39:8]};
        if (len8 && payload[39:8] != npd_pkg::NA32) dec_kind = npd_pkg::KIND_DEPTH;
      end
      npd_pkg::PGN_WATER_SPEED: begin
        if (len8 && payload[23:8] != npd_pkg::NA16) dec_kind = npd_pkg::KIND_WATER_SPEED;
      end
      npd_pkg::PGN_WIND: begin
        dec_ang_raw = payload[39:24];
        if (len6 && payload[23:8] != npd_pkg::NA16 && payload[39:24] != npd_pkg::NA16) begin
          case (payload[42:40])
            npd_pkg::WREF_APPARENT:   dec_kind = npd_pkg::KIND_APPARENT_WIND;
            npd_pkg::WREF_BOAT_A:     dec_kind = npd_pkg::KIND_TRUE_WIND_BOAT;
            npd_pkg::WREF_BOAT_B:     dec_kind = npd_pkg::KIND_TRUE_WIND_BOAT;
            npd_pkg::WREF_TRUE_NORTH: dec_kind = npd_pkg::KIND_TRUE_WIND_NORTH;
            default:                  dec_kind = npd_pkg::KIND_NONE;
          endcase
        end
      end
      default: dec_rec = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_rec     <= dec_rec;
    s1_kind    <= dec_kind;
    s1_vv      <= dec_vv;
    s1_vsign   <= payload[55];
    s1_ang_raw <= dec_ang_raw;
    // magnitude of the signed variation, two's complement negated
    s1_var_mag <= payload[55] ? 17'h10000 - {1'b0, payload[55:40]} : {1'b0, payload[55:40]};
    s1_spd_raw <= dec_spd_raw;
    s1_dir_a   <= dec_dir_a;
    s1_dir_b   <= dec_dir_b;
    s1_off     <= payload[55:40];
    s1_off_ok  <= dec_off_ok;
  end

  // ---------------- conversion units ----------------
  logic [18:0]        ang_mdeg;
  logic [18:0]        var_mdeg_mag;
  npd_pkg::spd_part_t spd_part;

  npd_ang_conv u_ang (
    .clk  (clk),
    .mag  ({1'b0, s1_ang_raw}),
    .mdeg (ang_mdeg)
  );

  npd_ang_conv u_var (
    .clk  (clk),
    .mag  (s1_var_mag),
    .mdeg (var_mdeg_mag)
  );

  npd_spd_conv u_spd (
    .clk  (clk),
    .raw  (s1_spd_raw),
    .part (spd_part)
  );

  // ---------------- stage 2: depth scaling ----------------
  logic               s2_valid;
  logic               s2_rec;
  npd_pkg::kind_t     s2_kind;
  logic               s2_vv;
  logic               s2_vsign;
  logic signed [36:0] s2_dir_a;
  logic signed [31:0] s2_dir_b;
  logic [15:0]        s2_off;
  logic               s2_off_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_rec    <= s1_rec;
    s2_kind   <= s1_kind;
    s2_vv     <= s1_vv;
    s2_vsign  <= s1_vsign;
    s2_dir_b  <= s1_dir_b;
    s2_off    <= s1_off;
    s2_off_ok <= s1_off_ok;
    // depth * 10 as (d << 3) + (d << 1)
    if (s1_kind == npd_pkg::KIND_DEPTH)
      s2_dir_a <= {2'b00, s1_dir_a[31:0], 3'b000} + {4'b0000, s1_dir_a[31:0], 1'b0};
    else
      s2_dir_a <= s1_dir_a;
  end

  // ---------------- stage 3: keel offset ----------------
  logic               s3_valid;
  logic               s3_rec;
  npd_pkg::kind_t     s3_kind;
  logic               s3_vv;
  logic               s3_vsign;
  logic signed [36:0] s3_dir_a;
  logic signed [31:0] s3_dir_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_rec   <= s2_rec;
    s3_kind  <= s2_kind;
    s3_vv    <= s2_vv;
    s3_vsign <= s2_vsign;
    s3_dir_b <= s2_dir_b;
    if (s2_kind == npd_pkg::KIND_DEPTH && s2_off_ok)
      s3_dir_a <= s2_dir_a + {{21{s2_off[15]}}, s2_off};
    else
      s3_dir_a <= s2_dir_a;
  end

  // ---------------- stage 4: wrap and sign ----------------
  logic               s4_valid;
  logic               s4_rec;
  npd_pkg::kind_t     s4_kind;
  logic               s4_vv;
  logic signed [36:0] s4_dir_a;
  logic signed [31:0] s4_dir_b;
  logic [18:0]        s4_ang;
  logic signed [18:0] s4_var;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_rec   <= s3_rec;
    s4_kind  <= s3_kind;
    s4_vv    <= s3_vv;
    s4_dir_a <= s3_dir_a;
    s4_dir_b <= s3_dir_b;
    s4_ang   <= (ang_mdeg >= npd_pkg::FULL_TURN) ? ang_mdeg - npd_pkg::FULL_TURN : ang_mdeg;
    s4_var   <= s3_vsign ? -signed'(var_mdeg_mag) : signed'(var_mdeg_mag);
  end

  // ---------------- stage 5: assemble ----------------
  logic [20:0]        spd_q;
  logic signed [20:0] thd_sum;
  logic [18:0]        thd;
  logic signed [36:0] a_next;
  logic signed [31:0] b_next;
  logic               thv_next;

  assign spd_q   = spd_part.q_est + 21'(spd_part.rem >= 11'(npd_pkg::SPD_DIV));
  assign thd_sum = signed'({2'b00, s4_ang}) + 21'(s4_var);

  always_comb begin
    if (thd_sum < 0)
      thd = 19'(thd_sum + 21'(npd_pkg::FULL_TURN));
    else if (thd_sum >= signed'({2'b00, npd_pkg::FULL_TURN}))
      thd = 19'(thd_sum - 21'(npd_pkg::FULL_TURN));
    else
      thd = thd_sum[18:0];
  end

  always_comb begin
    a_next   = '0;
    b_next   = '0;
    thv_next = 1'b0;
    case (s4_kind)
      npd_pkg::KIND_POSITION: begin
        a_next = s4_dir_a;
        b_next = s4_dir_b;
      end
      npd_pkg::KIND_COG_SOG: begin
        a_next = {18'd0, s4_ang};
        b_next = {11'd0, spd_q};
      end
      npd_pkg::KIND_HDG_TRUE: a_next = {18'd0, s4_ang};
      npd_pkg::KIND_HDG_MAG: begin
        b_next   = {13'd0, s4_ang};
        thv_next = s4_vv;
        if (s4_vv) a_next = {18'd0, thd};
      end
      npd_pkg::KIND_VAR_ONLY:    a_next = '0;
      npd_pkg::KIND_DEPTH:       a_next = s4_dir_a;
      npd_pkg::KIND_WATER_SPEED: a_next = {16'd0, spd_q};
      npd_pkg::KIND_APPARENT_WIND, npd_pkg::KIND_TRUE_WIND_BOAT,
      npd_pkg::KIND_TRUE_WIND_NORTH: begin
        a_next = {16'd0, spd_q};
        b_next = {13'd0, s4_ang};
      end
      default: a_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    recognized         <= s4_rec;
    kind               <= s4_kind;
    value_a            <= a_next;
    value_b            <= b_next;
    variation_mdeg     <= s4_vv ? s4_var : '0;
    variation_valid    <= s4_vv;
    true_heading_valid <= thv_next;
  end

  assign busy = 1'b0;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##5 done)
    else $error("request did not produce a result after five cycles");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && kind == npd_pkg::KIND_NONE |->
      value_a == 0 && value_b == 0 && !variation_valid && variation_mdeg == 0)
    else $error("kind none with non-zero fields");

  a_thv: assert property (@(posedge clk) disable iff (rst)
    done && true_heading_valid |-> kind == npd_pkg::KIND_HDG_MAG && variation_valid)
    else $error("true heading flagged outside magnetic heading with variation");

  a_cog_range: assert property (@(posedge clk) disable iff (rst)
    done && kind == npd_pkg::KIND_COG_SOG |->
      value_a >= 0 && value_a < 37'(npd_pkg::FULL_TURN))
    else $error("course over ground out of range");
`endif

endmodule

// ----- test/nav_pgn_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// nav_pgn_decoder_core_tb: self-checking bench for the navigation PGN decoder
// Runs directed frames for each handled PGN and its corner cases, then random
// bursts of mostly well-formed frames. Every accepted request is decoded by a
// behavioural model, and each done strobe is checked in order against it.
// ----------------------------------------------------------------------------
module nav_pgn_decoder_core_tb;

  localparam int unsigned N_RANDOM   = 1950;
  localparam int unsigned PIPE_DEPTH = 5;

  localparam longint unsigned MDEG_Q32  = 64'd24608349921; // 18/pi, Q32
  localparam longint          TURN_MDEG = 360000;

  localparam logic [1:0]  COG_REF_MAG   = 2'd1;
  localparam logic [1:0]  HREF_ERROR    = 2'd2;
  localparam logic [1:0]  HREF_NULL     = 2'd3;
  localparam logic [2:0]  WREF_MAGNETIC = 3'd1;
  localparam logic [2:0]  WREF_SPARE    = 3'd7;
  localparam logic [17:0] PGN_AIS_A     = 18'd129038;

  typedef struct packed {
    logic                recognized;
    npd_pkg::kind_t      kind;
    logic signed [36:0]  value_a;
    logic signed [31:0]  value_b;
    logic signed [18:0]  variation_mdeg;
    logic                variation_valid;
    logic                true_heading_valid;
  } nav_fix_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [17:0]        pgn;
  logic [63:0]        payload;
  logic [7:0]         payload_len;
  logic               done;
  logic               recognized;
  logic [3:0]         kind;
  logic signed [36:0] value_a;
  logic signed [31:0] value_b;
  logic signed [18:0] variation_mdeg;
  logic               variation_valid;
  logic               true_heading_valid;

  nav_pgn_decoder_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .pgn                (pgn),
    .payload            (payload),
    .payload_len        (payload_len),
    .done               (done),
    .recognized         (recognized),
    .kind               (kind),
    .value_a            (value_a),
    .value_b            (value_b),
    .variation_mdeg     (variation_mdeg),
    .variation_valid    (variation_valid),
    .true_heading_valid (true_heading_valid)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Conversions
  // --------------------------------------------------------------------------
  function automatic longint mdeg_round(longint unsigned mag);
    return longint'((mag * MDEG_Q32 + 64'h8000_0000) >> 32);
  endfunction

  function automatic longint mdeg_wrapped(logic [15:0] raw);
    longint r;
    r = mdeg_round(raw);
    while (r >= TURN_MDEG) r -= TURN_MDEG;
    return r;
  endfunction

  // magnitude is rounded, so halves go away from zero
  function automatic longint mdeg_signed(logic [15:0] raw);
    if (raw[15]) return -mdeg_round(64'd65536 - raw);
    return mdeg_round(raw);
  endfunction

  function automatic longint mknots(logic [15:0] raw);
    return (longint'(raw) * 18000 + 463) / 926;
  endfunction

  function automatic nav_fix_t decode_frame(logic [17:0] f_pgn, logic [63:0] p,
                                            logic [7:0] len);
    nav_fix_t           fix;
    npd_pkg::kind_t     k;
    longint             a, b, var_md, hdg_md, t;
    logic               vv, thv;
    logic signed [31:0] lat, lon;
    logic signed [15:0] keel;
    fix    = '0;
    k      = npd_pkg::KIND_NONE;
    a      = 0;
    b      = 0;
    var_md = 0;
    vv     = 1'b0;
    thv    = 1'b0;
    fix.recognized = 1'b1;
    case (f_pgn)
      npd_pkg::PGN_POSITION: begin
        lat = p[31:0];
        lon = p[63:32];
        if (len >= 8 && p[31:0] != npd_pkg::NAI32 && p[63:32] != npd_pkg::NAI32) begin
          k = npd_pkg::KIND_POSITION;
          a = lat;
          b = lon;
        end
      end
      npd_pkg::PGN_COG_SOG: begin
        if (len >= 8 && p[31:16] != npd_pkg::NA16 && p[47:32] != npd_pkg::NA16
            && p[9:8] == npd_pkg::CREF_TRUE) begin
          k = npd_pkg::KIND_COG_SOG;
          a = mdeg_wrapped(p[31:16]);
          b = mknots(p[47:32]);
        end
      end
      npd_pkg::PGN_HEADING: begin
        if (len >= 8 && p[23:8] != npd_pkg::NA16) begin
          hdg_md = mdeg_wrapped(p[23:8]);
          if (p[55:40] != npd_pkg::NAI16) begin
            vv     = 1'b1;
            var_md = mdeg_signed(p[55:40]);
          end
          if (p[57:56] == npd_pkg::HREF_TRUE) begin
            k = npd_pkg::KIND_HDG_TRUE;
            a = hdg_md;
          end else if (p[57:56] == npd_pkg::HREF_MAG) begin
            k = npd_pkg::KIND_HDG_MAG;
            b = hdg_md;
            if (vv) begin
              t = hdg_md + var_md;
              if (t < 0) t += TURN_MDEG;
              if (t >= TURN_MDEG) t -= TURN_MDEG;
              a   = t;
              thv = 1'b1;
            end
          end else if (vv) begin
            k = npd_pkg::KIND_VAR_ONLY;
          end
          if (k == npd_pkg::KIND_NONE) begin
            vv     = 1'b0;
            var_md = 0;
          end
        end
      end
      npd_pkg::PGN_DEPTH: begin
        if (len >= 8 && p[39:8] != npd_pkg::NA32) begin
          k    = npd_pkg::KIND_DEPTH;
          a    = longint'(p[39:8]) * 10;
          keel = p[55:40];
          if (p[55:40] != npd_pkg::NAI16) a += keel;
        end
      end
      npd_pkg::PGN_WATER_SPEED: begin
        if (len >= 8 && p[23:8] != npd_pkg::NA16) begin
          k = npd_pkg::KIND_WATER_SPEED;
          a = mknots(p[23:8]);
        end
      end
      npd_pkg::PGN_WIND: begin
        if (len >= 6 && p[23:8] != npd_pkg::NA16 && p[39:24] != npd_pkg::NA16) begin
          case (p[42:40])
            npd_pkg::WREF_APPARENT:   k = npd_pkg::KIND_APPARENT_WIND;
            npd_pkg::WREF_BOAT_A,
            npd_pkg::WREF_BOAT_B:     k = npd_pkg::KIND_TRUE_WIND_BOAT;
            npd_pkg::WREF_TRUE_NORTH: k = npd_pkg::KIND_TRUE_WIND_NORTH;
            default:                  k = npd_pkg::KIND_NONE;
          endcase
          if (k != npd_pkg::KIND_NONE) begin
            a = mknots(p[23:8]);
            b = mdeg_wrapped(p[39:24]);
          end
        end
      end
      default: fix.recognized = 1'b0;
    endcase
    fix.kind               = k;
    fix.value_a            = 37'(a);
    fix.value_b            = 32'(b);
    fix.variation_mdeg     = 19'(var_md);
    fix.variation_valid    = vv;
    fix.true_heading_valid = thv;
    return fix;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------
  class nav_fix_scoreboard;
    nav_fix_t    expected_fixes[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_request(logic [17:0] f_pgn, logic [63:0] p, logic [7:0] len);
      expected_fixes.push_back(decode_frame(f_pgn, p, len));
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        if (mismatches < 10)
          $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(nav_fix_t seen);
      nav_fix_t want;
      if (expected_fixes.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with no request pending, kind %0d", $realtime, seen.kind);
        mismatches++;
        return;
      end
      want = expected_fixes.pop_front();
      compare_field("recognized", want.recognized, seen.recognized);
      compare_field("kind", want.kind, seen.kind);
      compare_field("value_a", want.value_a, seen.value_a);
      compare_field("value_b", want.value_b, seen.value_b);
      compare_field("variation_mdeg", want.variation_mdeg, seen.variation_mdeg);
      compare_field("variation_valid", want.variation_valid, seen.variation_valid);
      compare_field("true_heading_valid", want.true_heading_valid, seen.true_heading_valid);
    endfunction
  endclass

  nav_fix_scoreboard sb;

  always @(posedge clk) begin
    nav_fix_t seen;
    if (!rst) begin
      if (start && !busy) sb.note_request(pgn, payload, payload_len);
      if (done) begin
        seen.recognized         = recognized;
        seen.kind               = npd_pkg::kind_t'(kind);
        seen.value_a            = value_a;
        seen.value_b            = value_b;
        seen.variation_mdeg     = variation_mdeg;
        seen.variation_valid    = variation_valid;
        seen.true_heading_valid = true_heading_valid;
        sb.check_result(seen);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame builders and random fields
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] cog_sog_frame(logic [63:0] fill, logic [1:0] cref,
                                                logic [15:0] cog, logic [15:0] sog);
    logic [63:0] p;
    p        = fill;
    p[9:8]   = cref;
    p[31:16] = cog;
    p[47:32] = sog;
    return p;
  endfunction

  function automatic logic [63:0] heading_frame(logic [63:0] fill, logic [15:0] hdg,
                                                logic [15:0] vari, logic [1:0] href);
    logic [63:0] p;
    p         = fill;
    p[23:8]   = hdg;
    p[55:40]  = vari;
    p[57:56]  = href;
    return p;
  endfunction

  function automatic logic [63:0] depth_frame(logic [63:0] fill, logic [31:0] dep,
                                              logic [15:0] keel);
    logic [63:0] p;
    p        = fill;
    p[39:8]  = dep;
    p[55:40] = keel;
    return p;
  endfunction

  function automatic logic [63:0] speed_frame(logic [63:0] fill, logic [15:0] spd);
    logic [63:0] p;
    p       = fill;
    p[23:8] = spd;
    return p;
  endfunction

  function automatic logic [63:0] wind_frame(logic [63:0] fill, logic [15:0] spd,
                                             logic [15:0] ang, logic [2:0] wref);
    logic [63:0] p;
    p        = fill;
    p[23:8]  = spd;
    p[39:24] = ang;
    p[42:40] = wref;
    return p;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 11))
      0:       return npd_pkg::NA16;
      1:       return npd_pkg::NAI16;
      2:       return 16'h0000;
      3:       return 16'h8000;
      4:       return 16'(62830 + $urandom_range(0, 3)); // around a full turn
      5:       return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 11))
      0:       return npd_pkg::NA32;
      1:       return npd_pkg::NAI32;
      2:       return 32'h0000_0000;
      3:       return 32'h8000_0000;
      4:       return 32'hFFFF_FFFE;
      5:       return 32'h7FFF_FFFE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_len();
    case ($urandom_range(0, 7))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(5, 7));
      default: return 8'd8;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_frame(logic [17:0] f_pgn, logic [63:0] f_payload, logic [7:0] f_len);
    start       <= 1'b1;
    pgn         <= f_pgn;
    payload     <= f_payload;
    payload_len <= f_len;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_fixes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_frame();
    logic [63:0] fill;
    logic [17:0] f_pgn;
    logic [63:0] p;
    fill = rnd64();
    case ($urandom_range(0, 13))
      0, 1: begin
        f_pgn = npd_pkg::PGN_POSITION;
        p     = {pick32(), pick32()};
      end
      2, 3: begin
        f_pgn = npd_pkg::PGN_COG_SOG;
        p     = cog_sog_frame(fill,
                              ($urandom_range(0, 2) == 0) ? 2'($urandom) : npd_pkg::CREF_TRUE,
                              pick16(), pick16());
      end
      4, 5: begin
        f_pgn = npd_pkg::PGN_HEADING;
        p     = heading_frame(fill, pick16(), pick16(), 2'($urandom));
      end
      6, 7: begin
        f_pgn = npd_pkg::PGN_DEPTH;
        p     = depth_frame(fill, pick32(), pick16());
      end
      8, 9: begin
        f_pgn = npd_pkg::PGN_WATER_SPEED;
        p     = speed_frame(fill, pick16());
      end
      10, 11: begin
        f_pgn = npd_pkg::PGN_WIND;
        p     = wind_frame(fill, pick16(), pick16(), 3'($urandom));
      end
      default: begin
        p = fill;
        case ($urandom_range(0, 2))
          0:       f_pgn = 18'($urandom);
          1:       f_pgn = PGN_AIS_A + 18'($urandom_range(0, 3));
          default: f_pgn = npd_pkg::PGN_WIND + 18'($urandom_range(1, 2));
        endcase
      end
    endcase
    send_frame(f_pgn, p, pick_len());
  endtask

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    sb          = new();
    rst         = 1'b1;
    start       = 1'b0;
    pgn         = '0;
    payload     = '0;
    payload_len = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and the not-available / reference corners
    send_frame(npd_pkg::PGN_POSITION, {32'h7FFF_FFFE, 32'h8000_0000}, 8'd8);
    send_frame(npd_pkg::PGN_POSITION, {32'hFFFF_FFFF, npd_pkg::NAI32}, 8'd8);
    send_frame(npd_pkg::PGN_POSITION, {npd_pkg::NAI32, 32'h0000_0001}, 8'd255);
    send_frame(npd_pkg::PGN_POSITION, {32'h0000_0000, 32'hFFFF_FFFF}, 8'd7);
    send_frame(npd_pkg::PGN_COG_SOG,
               cog_sog_frame(rnd64(), npd_pkg::CREF_TRUE, 16'h0000, 16'h0000), 8'd8);
    send_frame(npd_pkg::PGN_COG_SOG,
               cog_sog_frame(rnd64(), npd_pkg::CREF_TRUE, 16'hFFFE, 16'hFFFE), 8'd8);
    send_frame(npd_pkg::PGN_COG_SOG,
               cog_sog_frame(rnd64(), COG_REF_MAG, 16'd1000, 16'd500), 8'd8);
    send_frame(npd_pkg::PGN_COG_SOG,
               cog_sog_frame(rnd64(), npd_pkg::CREF_TRUE, 16'd1000, npd_pkg::NA16), 8'd8);
    send_frame(npd_pkg::PGN_HEADING,
               heading_frame(rnd64(), 16'd31416, npd_pkg::NAI16, npd_pkg::HREF_TRUE), 8'd8);
    // most negative variation pulls a zero heading below zero
    send_frame(npd_pkg::PGN_HEADING,
               heading_frame(rnd64(), 16'd0, 16'h8000, npd_pkg::HREF_MAG), 8'd8);
    send_frame(npd_pkg::PGN_HEADING,
               heading_frame(rnd64(), 16'd62831, 16'h7FFE, npd_pkg::HREF_MAG), 8'd8);
    send_frame(npd_pkg::PGN_HEADING,
               heading_frame(rnd64(), 16'd12345, npd_pkg::NAI16, npd_pkg::HREF_MAG), 8'd8);
    send_frame(npd_pkg::PGN_HEADING,
               heading_frame(rnd64(), 16'd12345, 16'd100, HREF_ERROR), 8'd8);
    send_frame(npd_pkg::PGN_HEADING,
               heading_frame(rnd64(), 16'd12345, npd_pkg::NAI16, HREF_NULL), 8'd8);
    send_frame(npd_pkg::PGN_HEADING,
               heading_frame(rnd64(), npd_pkg::NA16, 16'd100, npd_pkg::HREF_TRUE), 8'd8);
    send_frame(npd_pkg::PGN_DEPTH, depth_frame(rnd64(), 32'hFFFF_FFFE, 16'h7FFE), 8'd8);
    send_frame(npd_pkg::PGN_DEPTH, depth_frame(rnd64(), 32'h0000_0000, npd_pkg::NAI16), 8'd8);
    send_frame(npd_pkg::PGN_DEPTH, depth_frame(rnd64(), 32'h0000_0000, 16'h8000), 8'd8);
    send_frame(npd_pkg::PGN_DEPTH, depth_frame(rnd64(), npd_pkg::NA32, 16'd0), 8'd8);
    send_frame(npd_pkg::PGN_WATER_SPEED, speed_frame(rnd64(), 16'hFFFE), 8'd255);
    send_frame(npd_pkg::PGN_WATER_SPEED, speed_frame(rnd64(), npd_pkg::NA16), 8'd8);
    send_frame(npd_pkg::PGN_WIND,
               wind_frame(rnd64(), 16'd0, 16'hFFFE, npd_pkg::WREF_APPARENT), 8'd6);
    send_frame(npd_pkg::PGN_WIND,
               wind_frame(rnd64(), 16'hFFFE, 16'd0, npd_pkg::WREF_BOAT_A), 8'd8);
    send_frame(npd_pkg::PGN_WIND,
               wind_frame(rnd64(), 16'd777, 16'd40000, npd_pkg::WREF_TRUE_NORTH), 8'd7);
    send_frame(npd_pkg::PGN_WIND,
               wind_frame(rnd64(), 16'd777, 16'd40000, WREF_MAGNETIC), 8'd8);
    send_frame(npd_pkg::PGN_WIND,
               wind_frame(rnd64(), 16'd777, 16'd40000, WREF_SPARE), 8'd8);
    send_frame(npd_pkg::PGN_WIND,
               wind_frame(rnd64(), 16'd777, 16'd40000, npd_pkg::WREF_BOAT_B), 8'd5);
    send_frame(PGN_AIS_A, rnd64(), 8'd8);
    send_frame(18'h3FFFF, rnd64(), 8'd8);
    drain_results();

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random_frame();
        sent++;
      end
      case ($urandom_range(0, 19))
        0:             drain_results();
        1, 2, 3, 4, 5: ;
        default:       pause_sender($urandom_range(1, 12));
      endcase
    end

    drain_results();
    repeat (PIPE_DEPTH + 5) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_fixes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/npd_pkg.sv
rtl/npd_ang_conv.sv
rtl/npd_spd_conv.sv
rtl/nav_pgn_decoder_core.sv
test/nav_pgn_decoder_core_tb.sv
